### design/pcmf_pkg.sv
// Package with status codes, format codes and container size constants.
package pcmf_pkg;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_BAD_VALID    = 3'd1,
    ST_BAD_PCM      = 3'd2,
    ST_FLOAT_UNIMPL = 3'd3,
    ST_BAD_FLOAT    = 3'd4
  } status_t;

  localparam logic       FMT_INT   = 1'b0;
  localparam logic       FMT_FLOAT = 1'b1;

  localparam logic [6:0] BITS_8  = 7'd8;
  localparam logic [6:0] BITS_16 = 7'd16;
  localparam logic [6:0] BITS_20 = 7'd20;
  localparam logic [6:0] BITS_24 = 7'd24;
  localparam logic [6:0] BITS_32 = 7'd32;
  localparam logic [6:0] BITS_64 = 7'd64;

  localparam logic [1:0] CFG_FORMAT_KIND    = 2'd0;
  localparam logic [1:0] CFG_CONTAINER_BITS = 2'd1;
  localparam logic [1:0] CFG_VALID_BITS     = 2'd2;

  typedef struct packed {
    logic [31:0] float_bits;
    status_t     status;
  } result_t;

endpackage

### design/pcm_sample_to_float_converter.sv
// Top level: PCM or float64 sample stream to float32 stream converter.
//
// The input stream carries one sample container per transfer on in_tdata
// (byte zero in the lowest bits). Each transfer yields exactly one result
// transfer on the output stream: the float32 bit pattern and a status code.
// The format is set through the configuration port (format kind, container
// size, valid bits), only while the stream is idle: the user must keep to
// this, the block itself does not enforce it. Reset restores integer PCM in
// 16-bit containers.
// The input container is registered on acceptance, converted by a short
// combinational path and captured in the output register that drives the
// result transfer. While the receiver does not stall, one item can be taken
// in every cycle; throughput is one sample per cycle, set by the single
// conversion stage between the two registers.
// When the receiver holds out_tready low the output register keeps its
// value and the stall propagates back one stage: the input register keeps
// accepting only while its contents can advance. Reset is synchronous and
// active low; it empties both stages.
module pcm_sample_to_float_converter
  import pcmf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // raw_sample[63:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // float_bits[31:0], status[34:32], zero fill
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_wdata
);

  logic        fmt_r;
  logic [6:0]  cont_r;
  logic [6:0]  vbits_r;
  logic        s1_valid_r;
  logic [63:0] s1_data_r;
  logic        s2_valid_r;
  result_t     s2_res_r;
  result_t     conv_res;
  logic        s2_ready;
  logic        s1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r   <= FMT_INT;
      cont_r  <= BITS_16;
      vbits_r <= BITS_16;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FORMAT_KIND:    fmt_r   <= cfg_wdata[0];
        CFG_CONTAINER_BITS: cont_r  <= cfg_wdata;
        CFG_VALID_BITS:     vbits_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  pcmf_convert u_convert (
    .format_kind   (fmt_r),
    .container_bits(cont_r),
    .valid_bits    (vbits_r),
    .raw_sample    (s1_data_r),
    .result        (conv_res)
  );

  assign s2_ready  = !s2_valid_r || out_tready;
  assign s1_ready  = !s1_valid_r || s2_ready;
  assign in_tready = s1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_r <= in_tvalid;
      if (s2_ready) s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_tvalid) s1_data_r <= in_tdata;
    if (s2_ready && s1_valid_r) s2_res_r <= conv_res;
  end

  assign out_tvalid = s2_valid_r;
  assign out_tdata  = {5'd0, s2_res_r.status, s2_res_r.float_bits};

`ifndef SYNTHESIS
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");
  a_s1_advance: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s2_ready |=> s2_valid_r)
    else $error("item lost between stages");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[34:32] != ST_OK |-> out_tdata[31:0] == 32'd0)
    else $error("error result with nonzero data");
`endif

endmodule

### design/pcmf_convert.sv
// Combinational conversion of one sample container to a float32 bit pattern.
module pcmf_convert
  import pcmf_pkg::*;
(
  input  logic        format_kind,
  input  logic [6:0]  container_bits,
  input  logic [6:0]  valid_bits,
  input  logic [63:0] raw_sample,
  output result_t     result
);

  logic signed [32:0] ival;
  logic        [32:0] mag;
  logic               ineg;
  logic        [5:0]  msb;
  logic        [5:0]  lz;
  logic        [32:0] norm;
  logic        [24:0] m_int;
  logic               rnd_i;
  logic        [7:0]  e_int;
  logic        [31:0] int_bits;
  logic        [31:0] f64_bits;
  logic        [10:0] bexp;
  logic        [51:0] frac;
  logic signed [12:0] e64;
  logic        [24:0] m64;
  logic               rnd_f;
  logic signed [12:0] e64r;
  logic               vb_ok;
  logic signed [31:0] s24;
  logic signed [31:0] s32;
  status_t            st;

  always_comb begin
    // PCM decode into a signed value.
    ival = '0;
    st   = ST_OK;
    s24  = {{8{raw_sample[23]}}, raw_sample[23:0]};
    s32  = raw_sample[31:0];
    vb_ok = (valid_bits == BITS_16) || (valid_bits == BITS_20) || (valid_bits == BITS_24);
    case (container_bits)
      BITS_8:  ival = 33'(signed'({1'b0, raw_sample[7:0]})) - 33'sd128;
      BITS_16: ival = 33'(signed'(raw_sample[15:0]));
      BITS_24: begin
        if (!vb_ok) st = ST_BAD_VALID;
        else ival = 33'(s24 >>> (BITS_24 - valid_bits));
      end
      BITS_32: begin
        if (!(vb_ok || valid_bits == BITS_32)) st = ST_BAD_VALID;
        else ival = 33'(s32 >>> (BITS_32 - valid_bits));
      end
      default: st = ST_BAD_PCM;
    endcase

    ineg = ival[32];
    mag  = ineg ? 33'(-ival) : 33'(ival);
    msb  = '0;
    for (int i = 0; i < 33; i++) begin
      if (mag[i]) msb = 6'(i);
    end
    lz    = 6'd32 - msb;
    norm  = mag << lz;
    // norm[32] is the hidden bit; 23 fraction bits at [31:9].
    rnd_i = norm[8] && ((|norm[7:0]) || norm[9]);
    m_int = {1'b0, norm[32:9]} + 25'(rnd_i);
    e_int = 8'd127 + 8'(msb) + 8'(m_int[24]);
    if (mag == '0) int_bits = '0;
    else int_bits = {ineg, e_int, m_int[24] ? m_int[23:1] : m_int[22:0]};

    // Float64 narrowing.
    bexp  = raw_sample[62:52];
    frac  = raw_sample[51:0];
    e64   = 13'(signed'({2'b00, bexp})) - 13'sd896;
    m64   = {1'b0, 1'b1, frac[51:29]};
    rnd_f = frac[28] && ((|frac[27:0]) || frac[29]);
    m64   = m64 + 25'(rnd_f);
    e64r  = e64 + 13'(m64[24]);
    if (bexp == 11'h7FF) begin
      f64_bits = (frac == '0) ? {raw_sample[63], 31'h7F800000}
                              : {raw_sample[63], 31'h7FC00000 | 31'(frac[51:29])};
    end else if (bexp == '0 || e64 <= 13'sd0) begin
      f64_bits = {raw_sample[63], 31'd0};
    end else if (e64r >= 13'sd255) begin
      f64_bits = {raw_sample[63], 31'h7F800000};
    end else begin
      f64_bits = {raw_sample[63], e64r[7:0], m64[24] ? m64[23:1] : m64[22:0]};
    end

    result.float_bits = '0;
    result.status     = ST_OK;
    if (format_kind == FMT_INT) begin
      result.status = st;
      if (st == ST_OK) result.float_bits = int_bits;
    end else begin
      case (container_bits) inside
        BITS_16, BITS_24: result.status = ST_FLOAT_UNIMPL;
        BITS_32:          result.float_bits = raw_sample[31:0];
        BITS_64:          result.float_bits = f64_bits;
        default:          result.status = ST_BAD_FLOAT;
      endcase
    end
  end

endmodule

### tb/pcm_sample_to_float_converter_tb.sv
// Testbench for the PCM sample to float32 converter stream block.
`timescale 1ns / 100ps

module pcm_sample_to_float_converter_tb;
  import pcmf_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;   // raw_sample[63:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // float_bits[31:0], status[34:32], zero fill
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [6:0]  cfg_wdata;

  pcm_sample_to_float_converter u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // The predictor keeps its own copy of the three format registers.
  logic       fmt_kind;
  logic [6:0] cont_bits;
  logic [6:0] sig_bits;

  result_t pending_floats[$];
  int      mismatches;
  int      checked;

  // Stall controls shared by the sender, the receiver and the test tasks.
  bit sender_gaps;
  bit receiver_gaps;
  int hold_off_cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Round a magnitude to float32 with nearest-even rounding.
  function automatic logic [31:0] mag_to_float(input logic neg, input logic [63:0] mag);
    int          msb;
    int          sh;
    logic [63:0] man;
    logic [63:0] rem;
    logic [63:0] half;
    logic [8:0]  bexp;
    if (mag == 64'd0) return 32'd0;
    msb = 0;
    for (int i = 0; i < 64; i++) if (mag[i]) msb = i;
    bexp = 9'(127 + msb);
    if (msb <= 23) begin
      man = mag << (23 - msb);
    end else begin
      sh   = msb - 23;
      rem  = mag & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      man  = mag >> sh;
      if (rem > half || (rem == half && man[0])) man = man + 64'd1;
      if (man == (64'd1 << 24)) begin
        man  = man >> 1;
        bexp = bexp + 9'd1;
      end
    end
    return {neg, bexp[7:0], man[22:0]};
  endfunction

  // Narrow a float64 pattern to float32; tiny results flush to signed zero.
  function automatic logic [31:0] narrow_double(input logic [63:0] raw);
    logic        sgn;
    logic [10:0] dexp;
    logic [51:0] frac;
    int          e;
    logic [63:0] man;
    logic [28:0] rem;
    sgn  = raw[63];
    dexp = raw[62:52];
    frac = raw[51:0];
    if (dexp == 11'h7FF) begin
      if (frac == 52'd0) return {sgn, 31'h7F800000};
      return {sgn, 31'h7FC00000} | {9'd0, frac[51:29]};
    end
    if (dexp == 11'd0) return {sgn, 31'd0};
    e = int'(dexp) - 896;
    if (e >= 255) return {sgn, 31'h7F800000};
    if (e <= 0) return {sgn, 31'd0};
    man = {11'd0, 1'b1, frac} >> 29;
    rem = frac[28:0];
    if (rem > 29'h10000000 || (rem == 29'h10000000 && man[0])) man = man + 64'd1;
    if (man == (64'd1 << 24)) begin
      man = man >> 1;
      e   = e + 1;
    end
    if (e >= 255) return {sgn, 31'h7F800000};
    return {sgn, 8'(e), man[22:0]};
  endfunction

  function automatic result_t convert_sample(input logic [63:0] raw);
    result_t     r;
    longint      v;
    logic [63:0] u;
    logic [63:0] mag;
    int          sh;
    r.float_bits = 32'd0;
    r.status     = ST_OK;
    if (fmt_kind == FMT_INT) begin
      v = 0;
      case (cont_bits) inside
        BITS_8:  v = longint'(raw[7:0]) - 128;
        BITS_16: v = longint'($signed(raw[15:0]));
        BITS_24, BITS_32: begin
          if (!(sig_bits == BITS_16 || sig_bits == BITS_20 || sig_bits == BITS_24 ||
                (cont_bits == BITS_32 && sig_bits == BITS_32))) begin
            r.status = ST_BAD_VALID;
          end else begin
            u = raw & ((64'd1 << cont_bits) - 64'd1);
            if (cont_bits == BITS_24) v = longint'($signed(u[23:0]));
            else v = longint'($signed(u[31:0]));
            // An arithmetic shift floors, as the hardware shifter does.
            sh = int'(cont_bits) - int'(sig_bits);
            v  = v >>> sh;
          end
        end
        default: r.status = ST_BAD_PCM;
      endcase
      if (r.status == ST_OK) begin
        mag          = (v < 0) ? 64'(-v) : 64'(v);
        r.float_bits = mag_to_float(v < 0, mag);
      end
    end else begin
      case (cont_bits) inside
        BITS_16, BITS_24: r.status = ST_FLOAT_UNIMPL;
        BITS_32: r.float_bits = raw[31:0];
        BITS_64: r.float_bits = narrow_double(raw);
        default: r.status = ST_BAD_FLOAT;
      endcase
    end
    return r;
  endfunction

  // Registers are only written while the stream is idle.
  task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_FORMAT_KIND:    fmt_kind  = val[0];
      CFG_CONTAINER_BITS: cont_bits = val;
      default:            sig_bits  = val;
    endcase
  endtask

  // Stops offering and waits for every outstanding result.
  task automatic drain;
    in_tvalid <= 1'b0;
    while (pending_floats.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_format(input logic k, input logic [6:0] cb, input logic [6:0] vb);
    drain();
    write_reg(CFG_FORMAT_KIND, {6'd0, k});
    write_reg(CFG_CONTAINER_BITS, cb);
    write_reg(CFG_VALID_BITS, vb);
  endtask

  // Offers one sample and holds it until the transfer completes. The
  // expectation is queued at the accepting edge.
  task automatic send_sample(input logic [63:0] raw);
    if (sender_gaps && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= raw;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_floats.push_back(convert_sample(raw));
  endtask

  task automatic idle_input;
    in_tvalid <= 1'b0;
  endtask

  // Random container with the unused upper bits cleared, now and then left
  // dirty so that masking is exercised.
  function automatic logic [63:0] rand_raw;
    logic [63:0] r;
    r = {$urandom, $urandom};
    if ($urandom_range(0, 3) != 0 && cont_bits < BITS_64 && cont_bits != 7'd0)
      r = r & ((64'd1 << cont_bits) - 64'd1);
    return r;
  endfunction

  // Float64 patterns weighted to the float32 range limits, rounding ties and specials.
  function automatic logic [63:0] rand_double;
    logic [63:0] r;
    int          pick;
    r    = {$urandom, $urandom};
    pick = $urandom_range(0, 5);
    case (pick)
      0: r[62:52] = 11'(896 + $urandom_range(0, 254));
      1: r[62:52] = 11'($urandom_range(890, 900));
      2: r[62:52] = 11'($urandom_range(1148, 1153));
      3: begin
        r[62:52] = 11'(896 + $urandom_range(1, 254));
        r[28:0]  = 29'h10000000;
      end
      4: r[62:52] = ($urandom_range(0, 1) != 0) ? 11'h7FF : 11'd0;
      default: ;
    endcase
    return r;
  endfunction

  // Receiver: random stall bursts plus an optional long hold-off.
  initial begin
    out_tready <= 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_off_cycles > 0) begin
        out_tready <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk);
        hold_off_cycles = 0;
      end else if (receiver_gaps && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Result checker: compares each accepted result with the oldest one
  // predicted.
  initial begin
    result_t want;
    mismatches = 0;
    checked    = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        if (pending_floats.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", out_tdata);
        end else begin
          want = pending_floats.pop_front();
          checked++;
          if (out_tdata[31:0] !== want.float_bits || out_tdata[34:32] !== want.status ||
              out_tdata[39:35] !== 5'd0) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected bits %h status %0d, got bits %h status %0d (%h)",
                       want.float_bits, want.status, out_tdata[31:0], out_tdata[34:32],
                       out_tdata[39:35]);
          end
        end
      end
    end
  end

  // Reset values must give 16-bit integer PCM.
  task automatic test_reset_format;
    send_sample(64'h0000);
    send_sample(64'h7FFF);
    send_sample(64'h8000);
    send_sample(64'hFFFF_FFFF_FFFF_FFFF);
    idle_input();
  endtask

  // Directed extremes of integer 8/24/32 and float 32/64 containers; every error status.
  task automatic test_directed;
    set_format(FMT_INT, BITS_8, BITS_16);
    send_sample(64'h00);
    send_sample(64'h80);
    send_sample(64'hFF);
    set_format(FMT_INT, BITS_24, BITS_20);
    send_sample(64'h80_0000);
    send_sample(64'h7F_FFFF);
    send_sample(64'hFFFF_FFFF_FFFF_FFFF);
    set_format(FMT_INT, BITS_32, BITS_32);
    send_sample(64'h8000_0000);
    send_sample(64'h7FFF_FFFF);
    send_sample(64'h0100_0001);
    set_format(FMT_INT, BITS_24, BITS_32);
    send_sample(64'h12_3456);
    set_format(FMT_INT, BITS_64, BITS_16);
    send_sample(64'h1);
    set_format(FMT_FLOAT, BITS_24, BITS_16);
    send_sample(64'h1);
    set_format(FMT_FLOAT, 7'd127, BITS_8);
    send_sample(64'h1);
    set_format(FMT_FLOAT, BITS_32, 7'd127);
    send_sample(64'hDEAD_BEEF_7FC0_0001);
    set_format(FMT_FLOAT, BITS_64, BITS_16);
    send_sample(64'h7FF0_0000_0000_0000);
    send_sample(64'hFFF8_0000_2000_0000);
    send_sample(64'h8000_0000_0000_0001);
    send_sample(64'h47EF_FFFF_F000_0000);
    send_sample(64'h3810_0000_0000_0000);
    send_sample(64'h380F_FFFF_FFFF_FFFF);
    send_sample(64'h3FF0_0000_1000_0000);
    idle_input();
  endtask

  // Random samples under a randomly chosen format.
  task automatic test_random_format(input int n);
    logic [6:0] cb_pick[5];
    logic [6:0] vb_pick[5];
    logic       k;
    logic [6:0] cb;
    logic [6:0] vb;
    cb_pick = '{BITS_8, BITS_16, BITS_24, BITS_32, BITS_64};
    vb_pick = '{BITS_16, BITS_20, BITS_24, BITS_32, BITS_8};
    k  = ($urandom_range(0, 3) == 0);
    cb = ($urandom_range(0, 9) == 0) ? 7'($urandom) : cb_pick[$urandom_range(0, 4)];
    vb = ($urandom_range(0, 9) == 0) ? 7'($urandom) : vb_pick[$urandom_range(0, 3)];
    if (k == FMT_FLOAT && $urandom_range(0, 3) != 0)
      cb = ($urandom_range(0, 1) != 0) ? BITS_64 : BITS_32;
    set_format(k, cb, vb);
    for (int i = 0; i < n; i++)
      send_sample((k == FMT_FLOAT && cb == BITS_64) ? rand_double() : rand_raw());
    idle_input();
  endtask

  // The receiver stalls for a long stretch while the sender keeps offering.
  task automatic test_backpressure;
    set_format(FMT_INT, BITS_16, BITS_16);
    hold_off_cycles = 60;
    for (int i = 0; i < 40; i++) send_sample(rand_raw());
    idle_input();
    // The sender now pauses until every result has arrived.
    drain();
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= 64'd0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_FORMAT_KIND;
    cfg_wdata <= 7'd0;
    fmt_kind  = FMT_INT;
    cont_bits = BITS_16;
    sig_bits  = BITS_16;
    sender_gaps     = 1'b0;
    receiver_gaps   = 1'b0;
    hold_off_cycles = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_format();
    test_directed();
    sender_gaps   = 1'b1;
    receiver_gaps = 1'b1;
    test_backpressure();
    for (int p = 0; p < 30; p++) test_random_format(50);
    // Final stretch runs at full rate with the random gaps off on both sides.
    sender_gaps   = 1'b0;
    receiver_gaps = 1'b0;
    for (int p = 0; p < 6; p++) test_random_format(50);

    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_floats.size() == 0) begin
      $display("[pcm_sample_to_float_converter] OK");
    end else begin
      $display("[pcm_sample_to_float_converter] ERROR");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #5ms;
    $display("[pcm_sample_to_float_converter] ERROR");
    $finish;
  end

endmodule

### filelist.f
design/pcmf_pkg.sv
design/pcmf_convert.sv
design/pcm_sample_to_float_converter.sv
tb/pcm_sample_to_float_converter_tb.sv
